// File: hw/rtl/sba_pkg.sv
// Package: shared types and constants for the split block allocator
`default_nettype none
package sba_pkg;
  localparam int unsigned UNIT_SHIFT = 4;
  localparam logic [24:0] ALLOC_OVERHEAD = 25'd8;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_BLOCK = 2'd1,
    ST_Q_FULL   = 2'd2,
    ST_TOO_BIG  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_READ,
    S_SPLIT,
    S_DONE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic search_step;
    logic pop;
    logic split_step;
    logic free_push;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_free;
    logic too_big;
    logic found;
    logic search_end;
    logic split_end;
  } stat_t;
endpackage
`default_nettype wire

// File: hw/rtl/sba_ctrl.sv
// Controller state machine sequencing one request at a time
`default_nettype none
module sba_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire sba_pkg::stat_t st,
  output sba_pkg::cmd_t       cmd,
  output logic                busy,
  output logic                done
);
  sba_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= sba_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sba_pkg::S_IDLE:   if (start) state_nxt = sba_pkg::S_SEARCH;
      sba_pkg::S_SEARCH: begin
        if (st.too_big || st.is_free) state_nxt = sba_pkg::S_DONE;
        else if (st.found) state_nxt = sba_pkg::S_READ;
        else if (st.search_end) state_nxt = sba_pkg::S_DONE;
      end
      sba_pkg::S_READ:   state_nxt = sba_pkg::S_SPLIT;
      sba_pkg::S_SPLIT:  if (st.split_end) state_nxt = sba_pkg::S_DONE;
      sba_pkg::S_DONE:   state_nxt = sba_pkg::S_IDLE;
      default:           state_nxt = sba_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state_r)
      sba_pkg::S_IDLE: begin
        busy = 1'b0;
        cmd.load = start;
      end
      sba_pkg::S_SEARCH: begin
        cmd.free_push   = st.is_free && !st.too_big;
        cmd.search_step = !st.too_big && !st.is_free && !st.found;
        cmd.pop         = !st.too_big && !st.is_free && st.found;
      end
      sba_pkg::S_SPLIT: cmd.split_step = !st.split_end;
      sba_pkg::S_DONE:  done = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// File: hw/rtl/sba_dp.sv
// Datapath: level queues, size to level, search and split pushes
`default_nettype none
module sba_dp #(
  parameter int MAX_LEVELS  = 16,
  parameter int QUEUE_DEPTH = 256,
  parameter int ADDR_BITS   = 20
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [4:0]           levels_in_use,
  input  wire logic                 req_type,
  input  wire logic [23:0]          request_bytes,
  input  wire logic [19:0]          block_addr,
  input  wire logic [24:0]          block_bytes,
  input  wire sba_pkg::cmd_t        cmd,
  output sba_pkg::stat_t            st,
  output logic [1:0]                status,
  output logic [19:0]               granted_addr,
  output logic [3:0]                granted_level,
  output logic                      split_overflow
);
  localparam int LW = $clog2(MAX_LEVELS + 1);
  localparam int IW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int MW = $clog2(MAX_LEVELS * QUEUE_DEPTH);

  // per-level pointers and counts
  logic [QW-1:0] head_r  [MAX_LEVELS];
  logic [QW-1:0] tail_r  [MAX_LEVELS];
  logic [CW-1:0] count_r [MAX_LEVELS];
  logic [ADDR_BITS-1:0] mem [MAX_LEVELS * QUEUE_DEPTH];

  logic                 type_r;
  logic [LW-1:0]        nlev_r, target_r, lv_r;
  logic [ADDR_BITS-1:0] addr_r, faddr_r, rd_r;
  logic [1:0]           status_r;
  logic                 ovf_r, first_r;

  // ceiling log2 of a unit count (bytes rounded up to 16-byte units)
  function automatic logic [5:0] clog2_units(input logic [24:0] bytes);
    logic [25:0] u;
    logic [5:0]  r;
    u = ({1'b0, bytes} + 26'd15) >> sba_pkg::UNIT_SHIFT;
    r = '0;
    for (int i = 0; i < 22; i++)
      if ((26'd1 << i) < u) r = 6'(i + 1);
    return r;
  endfunction

  logic [5:0]    tgt_in;
  logic [LW-1:0] nlev_in;
  always_comb begin
    tgt_in = req_type ? clog2_units(block_bytes)
                      : clog2_units({1'b0, request_bytes} + sba_pkg::ALLOC_OVERHEAD);
    nlev_in = (levels_in_use > 5'(MAX_LEVELS)) ? LW'(MAX_LEVELS) : LW'(levels_in_use);
  end

  logic [IW-1:0] lv_i, lvm1_i;
  assign lv_i   = IW'(lv_r);
  assign lvm1_i = IW'(lv_r - 1'b1);

  // status to controller
  always_comb begin
    st.is_free    = type_r;
    st.too_big    = status_r == sba_pkg::ST_TOO_BIG;
    st.found      = (lv_r < nlev_r) && (count_r[lv_i] != '0);
    st.search_end = lv_r >= nlev_r;
    st.split_end  = lv_r == target_r;
  end

  logic [MW-1:0] push_idx, pop_idx;
  assign pop_idx  = MW'(lv_i) * MW'(QUEUE_DEPTH) + MW'(tail_r[lv_i]);
  assign push_idx = cmd.free_push ? MW'(lv_i) * MW'(QUEUE_DEPTH) + MW'(head_r[lv_i])
                                  : MW'(lvm1_i) * MW'(QUEUE_DEPTH) + MW'(head_r[lvm1_i]);

  logic                 push_en, push_ok;
  logic [IW-1:0]        push_lv;
  logic [ADDR_BITS-1:0] push_data;
  always_comb begin
    push_lv   = cmd.free_push ? lv_i : lvm1_i;
    push_en   = cmd.free_push || (cmd.split_step && !first_r);
    push_ok   = count_r[push_lv] < CW'(QUEUE_DEPTH);
    push_data = cmd.free_push ? faddr_r
                              : rd_r + (ADDR_BITS'(1) << lvm1_i);
  end

  // queue store; the popped word is held until the next pop
  always_ff @(posedge clk) begin
    if (push_en && push_ok) mem[push_idx] <= push_data;
    if (cmd.pop) rd_r <= mem[pop_idx];
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head_r[i] <= '0; tail_r[i] <= '0; count_r[i] <= '0;
      end
    end else if (cmd.pop) begin
      tail_r[lv_i]  <= (tail_r[lv_i] == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_r[lv_i] + 1'b1;
      count_r[lv_i] <= count_r[lv_i] - 1'b1;
    end else if (push_en && push_ok) begin
      head_r[push_lv]  <= (head_r[push_lv] == QW'(QUEUE_DEPTH - 1)) ? '0
                          : head_r[push_lv] + 1'b1;
      count_r[push_lv] <= count_r[push_lv] + 1'b1;
    end
  end

  // request registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_r   <= req_type;
      faddr_r  <= ADDR_BITS'(block_addr);
      nlev_r   <= nlev_in;
      target_r <= LW'(tgt_in);
      lv_r     <= LW'(tgt_in);
      addr_r   <= '0;
      ovf_r    <= 1'b0;
      status_r <= ({1'b0, tgt_in} >= 7'(nlev_in)) ? sba_pkg::ST_TOO_BIG
                                                  : sba_pkg::ST_NO_BLOCK;
      first_r  <= 1'b0;
    end else if (cmd.free_push) begin
      status_r <= push_ok ? sba_pkg::ST_OK : sba_pkg::ST_Q_FULL;
    end else if (cmd.search_step) begin
      lv_r <= lv_r + 1'b1;
    end else if (cmd.pop) begin
      status_r <= sba_pkg::ST_OK;
      first_r  <= 1'b1;
    end else if (cmd.split_step) begin
      if (first_r) begin
        addr_r  <= rd_r;
        first_r <= 1'b0;
      end else begin
        if (!push_ok) ovf_r <= 1'b1;
        lv_r <= lv_r - 1'b1;
      end
    end
  end

  // the fetched word lands in rd_r in the cycle after pop; capture it for grant
  logic [ADDR_BITS-1:0] grant;
  assign grant = first_r ? rd_r : addr_r;
  always_comb begin
    status         = status_r;
    granted_addr   = (status_r == sba_pkg::ST_OK && !type_r) ? 20'(grant) : '0;
    granted_level  = (status_r == sba_pkg::ST_TOO_BIG) ? '0 : 4'(target_r);
    split_overflow = ovf_r;
  end
endmodule
`default_nettype wire

// File: hw/rtl/split_block_allocator.sv
// Top level: split block allocator, controller plus datapath
// One request in flight; start is taken when busy is low. A free or an
// oversized request goes through search, result and idle. An allocate
// served above its target looks at each level in turn from the target,
// reads the store, captures the word, makes one split push per level it
// steps down, then shows the result and returns to idle. An allocate that
// finds no block looks at each level up to the levels in use, then shows
// the result. Each result appears for one cycle with out_valid; the
// receiver cannot stall.
`default_nettype none
module split_block_allocator #(
  parameter int MAX_LEVELS  = 16,
  parameter int QUEUE_DEPTH = 256,
  parameter int ADDR_BITS   = 20
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_levels_in_use,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_req_type,
  input  wire logic [23:0] in_request_bytes,
  input  wire logic [19:0] in_block_addr,
  input  wire logic [24:0] in_block_bytes,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [19:0]      out_granted_addr,
  output logic [3:0]       out_granted_level,
  output logic             out_split_overflow
);
  logic [4:0] levels_r;
  sba_pkg::cmd_t  cmd;
  sba_pkg::stat_t st;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n)      levels_r <= '0;
    else if (cfg_we) levels_r <= cfg_levels_in_use;
  end

  sba_ctrl u_ctrl (
    .clk, .rst_n, .start, .st, .cmd, .busy, .done(out_valid)
  );

  sba_dp #(.MAX_LEVELS(MAX_LEVELS), .QUEUE_DEPTH(QUEUE_DEPTH), .ADDR_BITS(ADDR_BITS)) u_dp (
    .clk, .rst_n, .levels_in_use(levels_r),
    .req_type(in_req_type), .request_bytes(in_request_bytes),
    .block_addr(in_block_addr), .block_bytes(in_block_bytes),
    .cmd, .st, .status(out_status), .granted_addr(out_granted_addr),
    .granted_level(out_granted_level), .split_overflow(out_split_overflow)
  );

  // a result is never shown while idle
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside a transfer");
  // accepted request leaves the block busy
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request not taken");
  // a free that finds its queue full never reports a split overflow
  a_free_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == sba_pkg::ST_Q_FULL) |-> !out_split_overflow)
    else $error("overflow on free");
endmodule
`default_nettype wire
